### rtl/ps2ma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2ma_pkg
// Shared types and constants for the PS/2 mouse packet accumulator.
// ----------------------------------------------------------------------------
package ps2ma_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DELTA_W  = 9;
  localparam int unsigned OUT_TOT_W = 16;
  localparam int unsigned OUT_DATA_W = 56;

  // header byte bit positions
  localparam int unsigned HDR_SYNC  = 3;
  localparam int unsigned HDR_XSIGN = 4;
  localparam int unsigned HDR_YSIGN = 5;
  localparam int unsigned HDR_XOVF  = 6;
  localparam int unsigned HDR_YOVF  = 7;

  // item kind carried on tuser
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    POS_HDR = 3'b001,
    POS_X   = 3'b010,
    POS_Y   = 3'b100
  } pos_t;

  typedef struct packed {
    logic                       done;
    logic [2:0]                 buttons;
    logic                       x_overflow;
    logic                       y_overflow;
    logic [DELTA_W-1:0]         delta_x;
    logic [DELTA_W-1:0]         delta_y;
  } pkt_t;

endpackage

### rtl/ps2_mouse_packet_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_accumulator
// Assembles three-byte PS/2 mouse packets and keeps saturating per-axis
// running totals of the movement.
// ----------------------------------------------------------------------------
// One transaction in per clock: each byte or clear is captured in an input
// register, handled by one pass of logic and, on the third byte of a packet,
// written to the result register, so a stream moves at one item per cycle
// while the output is not stalled. Headers must have bit 3 set; other bytes
// seen while waiting for a header are dropped. A clear zeroes both totals
// without touching packet framing. Totals are TOTAL_BITS wide and are
// reported as their low 16 bits (sign-extended when narrower).
module ps2_mouse_packet_accumulator #(
  parameter int unsigned TOTAL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] buttons, [3] x_overflow, [4] y_overflow, [13:5] delta_x,
  // [22:14] delta_y, [38:23] total_x, [54:39] total_y, [55] zero
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned OW = ps2ma_pkg::OUT_TOT_W;

  logic                          in_valid;
  logic                          in_func;
  logic [ps2ma_pkg::BYTE_W-1:0]  in_data;
  logic                          advance;
  ps2ma_pkg::pkt_t               pkt;
  logic [TOTAL_BITS-1:0]         tx_next;
  logic [TOTAL_BITS-1:0]         ty_next;
  logic [OW-1:0]                 tx_out;
  logic [OW-1:0]                 ty_out;
  logic                          clear;

  logic                          out_valid;
  logic [2:0]                    out_buttons;
  logic                          out_xovf;
  logic                          out_yovf;
  logic [ps2ma_pkg::DELTA_W-1:0] out_dx;
  logic [ps2ma_pkg::DELTA_W-1:0] out_dy;
  logic [OW-1:0]                 out_tx;
  logic [OW-1:0]                 out_ty;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign clear         = (in_func == ps2ma_pkg::FUNC_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func <= s_axis_tuser;
      in_data <= s_axis_tdata;
    end
  end

  ps2ma_track u_track (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .func      (in_func),
    .data_byte (in_data),
    .pkt       (pkt)
  );

  ps2ma_accum #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .clear        (clear),
    .pkt          (pkt),
    .total_x_next (tx_next),
    .total_y_next (ty_next)
  );

  generate
    if (TOTAL_BITS >= OW) begin : g_trunc
      assign tx_out = tx_next[OW-1:0];
      assign ty_out = ty_next[OW-1:0];
    end else begin : g_sext
      assign tx_out = {{(OW-TOTAL_BITS){tx_next[TOTAL_BITS-1]}}, tx_next};
      assign ty_out = {{(OW-TOTAL_BITS){ty_next[TOTAL_BITS-1]}}, ty_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pkt.done;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pkt.done) begin
      out_buttons <= pkt.buttons;
      out_xovf    <= pkt.x_overflow;
      out_yovf    <= pkt.y_overflow;
      out_dx      <= pkt.delta_x;
      out_dy      <= pkt.delta_y;
      out_tx      <= tx_out;
      out_ty      <= ty_out;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_ty, out_tx, out_dy, out_dx, out_yovf, out_xovf, out_buttons};

`ifndef ASSERT_OFF
  a_rise_from_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(advance) && $past(pkt.done))
    else $error("result appeared without a completed packet");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_func) && $stable(in_data))
    else $error("input register lost a pending transaction");
  a_total_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (TOTAL_BITS <= OW) |->
      out_tx[OW-1] == out_dx[ps2ma_pkg::DELTA_W-1] &&
      out_ty[OW-1] == out_dy[ps2ma_pkg::DELTA_W-1])
    else $error("reported total sign differs from delta sign");
`endif

endmodule

### rtl/ps2ma_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2ma_track
// Packet framing: tracks byte position, holds header and X byte, and forms
// the signed deltas when the third byte arrives.
// ----------------------------------------------------------------------------
module ps2ma_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          func,
  input  logic [ps2ma_pkg::BYTE_W-1:0]  data_byte,
  output ps2ma_pkg::pkt_t               pkt
);

  ps2ma_pkg::pos_t                     pos, pos_next;
  logic [ps2ma_pkg::BYTE_W-1:0]        header_byte;
  logic [ps2ma_pkg::BYTE_W-1:0]        x_byte;
  logic                                is_byte;

  assign is_byte = (func == ps2ma_pkg::FUNC_BYTE);

  always_comb begin
    pos_next = pos;
    unique case (pos)
      ps2ma_pkg::POS_X: pos_next = ps2ma_pkg::POS_Y;
      ps2ma_pkg::POS_Y: pos_next = ps2ma_pkg::POS_HDR;
      default: begin
        pos_next = data_byte[ps2ma_pkg::HDR_SYNC] ? ps2ma_pkg::POS_X : ps2ma_pkg::POS_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= ps2ma_pkg::POS_HDR;
    end else if (advance && is_byte) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= '0;
      x_byte      <= '0;
    end else if (advance && is_byte) begin
      if (pos != ps2ma_pkg::POS_X && pos != ps2ma_pkg::POS_Y &&
          data_byte[ps2ma_pkg::HDR_SYNC]) begin
        header_byte <= data_byte;
      end
      if (pos == ps2ma_pkg::POS_X) begin
        x_byte <= data_byte;
      end
    end
  end

  always_comb begin
    pkt.done       = is_byte && (pos == ps2ma_pkg::POS_Y);
    pkt.buttons    = header_byte[2:0];
    pkt.x_overflow = header_byte[ps2ma_pkg::HDR_XOVF];
    pkt.y_overflow = header_byte[ps2ma_pkg::HDR_YOVF];
    pkt.delta_x    = {header_byte[ps2ma_pkg::HDR_XSIGN], x_byte};
    pkt.delta_y    = {header_byte[ps2ma_pkg::HDR_YSIGN], data_byte};
  end

endmodule

### rtl/ps2ma_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2ma_accum
// Per-axis running totals: same-sign deltas add with saturation, opposite
// sign deltas replace the total, a clear zeroes both.
// ----------------------------------------------------------------------------
module ps2ma_accum #(
  parameter int unsigned TOTAL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  clear,
  input  ps2ma_pkg::pkt_t       pkt,
  output logic [TOTAL_BITS-1:0] total_x_next,
  output logic [TOTAL_BITS-1:0] total_y_next
);

  localparam int unsigned DW = ps2ma_pkg::DELTA_W;

  logic [TOTAL_BITS-1:0] total_x;
  logic [TOTAL_BITS-1:0] total_y;

  function automatic logic [TOTAL_BITS-1:0] upd(input logic [TOTAL_BITS-1:0] tot,
                                                input logic [DW-1:0] d);
    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] dext;
    dext = {{(TOTAL_BITS-DW){d[DW-1]}}, d};
    sum  = {tot[TOTAL_BITS-1], tot} + {dext[TOTAL_BITS-1], dext};
    if (tot[TOTAL_BITS-1] == d[DW-1]) begin
      if (sum[TOTAL_BITS] != sum[TOTAL_BITS-1]) begin
        upd = sum[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                              : {1'b0, {(TOTAL_BITS-1){1'b1}}};
      end else begin
        upd = sum[TOTAL_BITS-1:0];
      end
    end else begin
      upd = dext;
    end
  endfunction

  always_comb begin
    total_x_next = upd(total_x, pkt.delta_x);
    total_y_next = upd(total_y, pkt.delta_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_x <= '0;
      total_y <= '0;
    end else if (advance) begin
      if (clear) begin
        total_x <= '0;
        total_y <= '0;
      end else if (pkt.done) begin
        total_x <= total_x_next;
        total_y <= total_y_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_sign_x: assert property (@(posedge clk) disable iff (rst)
    advance && !clear && pkt.done |=> total_x[TOTAL_BITS-1] == $past(pkt.delta_x[DW-1]))
    else $error("X total sign differs from applied delta sign");
  a_sign_y: assert property (@(posedge clk) disable iff (rst)
    advance && !clear && pkt.done |=> total_y[TOTAL_BITS-1] == $past(pkt.delta_y[DW-1]))
    else $error("Y total sign differs from applied delta sign");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    advance && clear |=> total_x == '0 && total_y == '0)
    else $error("totals not zero after clear");
`endif

endmodule
